### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge while out of reset.
`define PCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication from a trigger to a consequence, checked in the same cycle.
`define PCS_ASSERT_IMPL(label, trig, cons, msg) \
    `PCS_ASSERT(label, (trig) |-> (cons), msg)

`endif

### hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, codes and widths shared by the pedestrian crossing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    // Width of the elapsed tick counter and of the demo countdown.
    localparam int COUNT_WIDTH = 16;
    // Width of a configuration register.
    localparam int CFG_W = 16;
    // Width used for comparing a count against a register.
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CFG_W-1:0]       cfg_word_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DEMAND_WAIT = 2'd0,
        REG_WALK        = 2'd1,
        REG_CLEARANCE   = 2'd2,
        REG_DEMO_TICKS  = 2'd3
    } reg_idx_t;

    localparam cfg_word_t DEMAND_WAIT_RESET = 16'd5;
    localparam cfg_word_t WALK_RESET        = 16'd10;
    localparam cfg_word_t CLEARANCE_RESET   = 16'd5;
    localparam cfg_word_t DEMO_TICKS_RESET  = 16'd30;

    // Input operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Signal status codes that release the waiting phases.
    localparam logic [1:0] ROAD_STOPPED   = 2'd1;
    localparam logic [1:0] WALKER_STOPPED = 2'd1;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_STOP_ROAD   = 3'd1,
        CMD_GO_ROAD     = 3'd2,
        CMD_WALK        = 3'd3,
        CMD_STOP_WALKER = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        SND_NONE   = 2'd0,
        SND_WAIT   = 2'd1,
        SND_CUCKOO = 2'd2
    } snd_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_DEMAND_WAIT = 3'd1,
        PH_ROAD_STOP   = 3'd2,
        PH_WALK        = 3'd3,
        PH_WALK_CUCKOO = 3'd4,
        PH_WALKER_STOP = 3'd5,
        PH_CLEARANCE   = 3'd6
    } phase_t;

    typedef struct packed {
        cfg_word_t demand_wait;
        cfg_word_t walk;
        cfg_word_t clearance;
        cfg_word_t demo_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t phase;
        cnt_t   elapsed;
        cnt_t   countdown;
        logic   lamp;
    } state_t;

    typedef struct packed {
        cmd_t   command;
        snd_t   sound;
        logic   lamp;
        phase_t phase;
    } result_t;

    // Brings a register value to the counter width.
    function automatic cnt_t cfg_to_cnt(input cfg_word_t v);
        cmp_t wide;
        wide = cmp_t'(v);
        return wide[COUNT_WIDTH-1:0];
    endfunction

    // True when a count has reached a register threshold.
    function automatic logic reached(input cnt_t cnt, input cfg_word_t thr);
        return cmp_t'(cnt) >= cmp_t'(thr);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pcs_step.sv
// ----------------------------------------------------------------------------
// pcs_step
// Next-state and result logic for one tick or press of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_step
    import pcs_pkg::*;
(
    input  var state_t     cur,
    input  var cfg_t       cfg,
    input  wire            op,
    input  wire  [1:0]     road_status,
    input  wire  [1:0]     walker_status,
    output state_t         nxt,
    output result_t        res
);

    cnt_t elapsed_inc;
    cnt_t countdown_dec;
    cmd_t cmd;
    snd_t snd;

    assign elapsed_inc   = (cur.elapsed == '1) ? cur.elapsed : cur.elapsed + cnt_t'(1);
    assign countdown_dec = cur.countdown - cnt_t'(1);

    always_comb
    begin
        nxt = cur;
        cmd = CMD_NONE;
        snd = SND_NONE;
        if (op == OP_PRESS)
        begin
            if (cur.phase == PH_IDLE)
            begin
                nxt.lamp    = 1'b1;
                nxt.elapsed = '0;
                nxt.phase   = PH_DEMAND_WAIT;
                snd         = SND_WAIT;
            end
            else if (cur.phase == PH_DEMAND_WAIT)
            begin
                snd = SND_WAIT;
            end
        end
        else
        begin
            nxt.elapsed = elapsed_inc;
            case (cur.phase)
                PH_IDLE:
                begin
                    nxt.countdown = countdown_dec;
                    if (countdown_dec == '0)
                    begin
                        nxt.lamp    = 1'b1;
                        nxt.elapsed = '0;
                        nxt.phase   = PH_DEMAND_WAIT;
                        snd         = SND_WAIT;
                    end
                end
                PH_DEMAND_WAIT:
                begin
                    if (reached(elapsed_inc, cfg.demand_wait))
                    begin
                        cmd       = CMD_STOP_ROAD;
                        nxt.phase = PH_ROAD_STOP;
                    end
                end
                PH_ROAD_STOP:
                begin
                    if (road_status == ROAD_STOPPED)
                    begin
                        nxt.lamp    = 1'b0;
                        cmd         = CMD_WALK;
                        nxt.elapsed = '0;
                        nxt.phase   = PH_WALK;
                    end
                end
                PH_WALK:
                begin
                    if (reached(elapsed_inc, cfg.walk))
                    begin
                        cmd       = CMD_STOP_WALKER;
                        nxt.phase = PH_WALKER_STOP;
                    end
                    else
                    begin
                        nxt.phase = PH_WALK_CUCKOO;
                    end
                end
                PH_WALK_CUCKOO:
                begin
                    snd       = SND_CUCKOO;
                    nxt.phase = PH_WALK;
                end
                PH_WALKER_STOP:
                begin
                    if (walker_status == WALKER_STOPPED)
                    begin
                        nxt.elapsed = '0;
                        nxt.phase   = PH_CLEARANCE;
                    end
                end
                PH_CLEARANCE:
                begin
                    if (reached(elapsed_inc, cfg.clearance))
                    begin
                        cmd           = CMD_GO_ROAD;
                        nxt.countdown = cfg_to_cnt(cfg.demo_ticks);
                        nxt.phase     = PH_IDLE;
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign res = '{command: cmd, sound: snd, lamp: nxt.lamp, phase: nxt.phase};

endmodule

`default_nettype wire

### hw/rtl/pedestrian_crossing_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pedestrian_crossing_sequencer_unit
// Seven-phase pedestrian crossing sequencer driven by ticks and button presses.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Word
//   -------   --------------------   ------------------------------------------
//   in        in_valid / in_stall    op, road_status, walker_status
//   out       out_valid / out_stall  command, sound_request, request_lamp, phase
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each input word yields exactly one output word. The sequencer state is updated
// in the cycle a word is accepted, and the result is registered, so a word can
// be taken every cycle while in_stall is low.
// The output register is backed by a one-word skid register; in_stall rises
// only while that skid register is full, i.e. after two results are waiting.
// Reset (asynchronous, active low) returns to idle, loads the register defaults
// and preloads the demo countdown. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pedestrian_crossing_sequencer_unit
    import pcs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        in_valid,
    output logic       in_stall,
    input  wire        op,
    input  wire  [1:0] road_status,
    input  wire  [1:0] walker_status,

    output logic       out_valid,
    input  wire        out_stall,
    output logic [2:0] command,
    output logic [1:0] sound_request,
    output logic       request_lamp,
    output logic [2:0] phase,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] cfg_index,
    input  wire [15:0] cfg_data
);

    // Configuration registers.
    cfg_t cfg_reg;

    // Sequencer state.
    state_t state_reg;
    state_t state_next;

    // Output register and the skid register behind it.
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    result_t step_res;
    logic    in_take;
    logic    out_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.demand_wait <= DEMAND_WAIT_RESET;
            cfg_reg.walk        <= WALK_RESET;
            cfg_reg.clearance   <= CLEARANCE_RESET;
            cfg_reg.demo_ticks  <= DEMO_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEMAND_WAIT: cfg_reg.demand_wait <= cfg_data;
                REG_WALK:        cfg_reg.walk        <= cfg_data;
                REG_CLEARANCE:   cfg_reg.clearance   <= cfg_data;
                REG_DEMO_TICKS:  cfg_reg.demo_ticks  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // The whole step is a short decision on the phase plus one increment and
    // one decrement, so it sits directly between the state and result registers.
    pcs_step u_step (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .op            (op),
        .road_status   (road_status),
        .walker_status (walker_status),
        .nxt           (state_next),
        .res           (step_res)
    );

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.elapsed   <= '0;
            state_reg.countdown <= cfg_to_cnt(DEMO_TICKS_RESET);
            state_reg.lamp      <= 1'b0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    // Output side: a result goes to the output register when that register is
    // free or being emptied; otherwise it parks in the skid register. The skid
    // register drains into the output register as soon as the output is taken,
    // and no new word is accepted in that cycle because in_stall is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_take)
            begin
                if (out_valid_reg && !out_take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = out_reg.command;
    assign sound_request = out_reg.sound;
    assign request_lamp  = out_reg.lamp;
    assign phase         = out_reg.phase;

    // A parked result always sits behind a pending one.
    `PCS_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a word while the output register is empty")
    // The skid register only fills while the output is held back.
    `PCS_ASSERT_IMPL(a_skid_fill, $rose(skid_valid_reg), $past(out_valid_reg && out_stall),
        "skid register filled without a stalled output")
    // A walk command always lands in the walking phase.
    `PCS_ASSERT_IMPL(a_walk_phase, out_valid_reg && (out_reg.command == CMD_WALK),
        out_reg.phase == PH_WALK, "walk command outside the walking phase")
    // The cuckoo sound is only heard on the way back into the walking phase.
    `PCS_ASSERT_IMPL(a_cuckoo_phase, out_valid_reg && (out_reg.sound == SND_CUCKOO),
        (out_reg.phase == PH_WALK) && (out_reg.command == CMD_NONE),
        "cuckoo sound outside the walking phase")

endmodule

`default_nettype wire
